// ===== rtl/assert_macros.svh =====
// assertion helpers included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside of reset
`define VT4_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every rising clock edge, reset included
`define VT4_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/vt4_pkg.sv =====
package vt4_pkg;

  // component and product widths
  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  // four products summed need two guard bits
  localparam int SUM_W  = PROD_W + 2;
  localparam int VEC_N  = 4;

  // configuration register file
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 64;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROW0_COLS01 = 3'd0,
    REG_ROW0_COLS23 = 3'd1,
    REG_ROW1_COLS01 = 3'd2,
    REG_ROW1_COLS23 = 3'd3,
    REG_ROW2_COLS01 = 3'd4,
    REG_ROW2_COLS23 = 3'd5,
    REG_ROW3_COLS01 = 3'd6,
    REG_ROW3_COLS23 = 3'd7
  } reg_idx_e;

  // element [i] is component i (x, y, z, w)
  typedef logic [VEC_N-1:0][DATA_W-1:0] vec_t;
  // element [r][c] is row r, column c
  typedef logic [VEC_N-1:0][VEC_N-1:0][DATA_W-1:0] mat_t;
  typedef logic [VEC_N-1:0][VEC_N-1:0][PROD_W-1:0] prod_t;

  typedef struct packed {
    vec_t comp;
    logic sat;
  } result_t;

endpackage

// ===== rtl/vt4_mat_regs.sv =====
module vt4_mat_regs #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [vt4_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [vt4_pkg::CFG_W-1:0]        cfg_data_i,
  output vt4_pkg::mat_t                    mat_o
);
  import vt4_pkg::*;

  // fixed-point one on the diagonal
  localparam logic [DATA_W-1:0] One    = DATA_W'(1) << FRAC_BITS;
  // one in the even (low) or odd (high) column of a register
  localparam logic [CFG_W-1:0]  DiagLo = CFG_W'(One);
  localparam logic [CFG_W-1:0]  DiagHi = {One, {DATA_W{1'b0}}};
  // identity, highest register index first
  localparam logic [NUM_REGS-1:0][CFG_W-1:0] RegsReset = {
    DiagHi, {CFG_W{1'b0}}, DiagLo, {CFG_W{1'b0}},
    {CFG_W{1'b0}}, DiagHi, {CFG_W{1'b0}}, DiagLo
  };

  logic [NUM_REGS-1:0][CFG_W-1:0] regs_q;
  logic                           idx_ok;

  // indexes past the last register are dropped
  assign idx_ok = (cfg_idx_i[CFG_IDX_W-1:REG_IDX_W] == '0);

  // register file, identity after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= RegsReset;
    end else if (cfg_we_i && idx_ok) begin
      regs_q[cfg_idx_i[REG_IDX_W-1:0]] <= cfg_data_i;
    end
  end

  // unpack two entries per register, even column low
  for (genvar r = 0; r < VEC_N; r++) begin : g_row
    for (genvar c = 0; c < VEC_N; c++) begin : g_col
      assign mat_o[r][c] = regs_q[2*r + c/2][DATA_W*(c%2) +: DATA_W];
    end
  end

endmodule

// ===== rtl/vt4_mul.sv =====
module vt4_mul (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  vt4_pkg::vec_t  vec_i,
  input  vt4_pkg::mat_t  mat_i,
  output logic           valid_o,
  input  logic           ready_i,
  output vt4_pkg::prod_t prod_o
);
  import vt4_pkg::*;

  logic  a_valid_q, b_valid_q;
  logic  a_ready, b_ready;
  vec_t  vec_q;
  prod_t prod_d, prod_q;

  // stage ready chain
  assign b_ready    = !b_valid_q || ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_stall_o = !a_ready;

  // sixteen full-precision products
  always_comb begin
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [PROD_W-1:0] p;
    prod_d = '0;
    for (int r = 0; r < VEC_N; r++) begin
      for (int c = 0; c < VEC_N; c++) begin
        a = mat_i[r][c];
        b = vec_q[c];
        p = a * b;
        prod_d[r][c] = p;
      end
    end
  end

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  // input beat and product registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && a_ready) begin
      vec_q <= vec_i;
    end
    if (a_valid_q && b_ready) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = b_valid_q;
  assign prod_o  = prod_q;

endmodule

// ===== rtl/vt4_sum_sat.sv =====
module vt4_sum_sat #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  vt4_pkg::prod_t   prod_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output vt4_pkg::result_t res_o
);
  import vt4_pkg::*;

  logic    out_valid_q;
  result_t res_d, res_q;

  // result register takes a beat when empty or draining
  assign ready_o = !out_valid_q || !out_stall_i;

  // row sums, floor shift and clamp
  always_comb begin
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  sh;
    logic signed [PROD_W-1:0] p;
    logic [SUM_W-DATA_W:0]    upper;
    res_d = '0;
    for (int r = 0; r < VEC_N; r++) begin
      sum = '0;
      for (int c = 0; c < VEC_N; c++) begin
        p   = prod_i[r][c];
        sum = sum + SUM_W'(p);
      end
      sh    = sum >>> FRAC_BITS;
      upper = sh[SUM_W-1:DATA_W-1];
      if ((&upper) || !(|upper)) begin
        res_d.comp[r] = sh[DATA_W-1:0];
      end else begin
        res_d.sat = 1'b1;
        res_d.comp[r] = sh[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                    : {1'b0, {(DATA_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_o) begin
      out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/vertex_transform_4x4.sv =====
// 4x4 fixed-point matrix times vector, one result beat per input beat
// throughput: one beat per cycle unless out_stall_i holds it; the stages are input, products, sum/clamp
// 16 parallel 32x32 multipliers feed a registered 66-bit row adder
// reset (rst_ni low, async): matrix returns to identity, pipeline empties
module vertex_transform_4x4 #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vt4_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [vt4_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            in_x_i,
  input  logic signed [31:0]            in_y_i,
  input  logic signed [31:0]            in_z_i,
  input  logic signed [31:0]            in_w_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            out_x_o,
  output logic signed [31:0]            out_y_o,
  output logic signed [31:0]            out_z_o,
  output logic signed [31:0]            out_w_o,
  output logic                          saturated_o
);
  import vt4_pkg::*;

  mat_t    mat;
  vec_t    in_vec;
  prod_t   prod;
  logic    prod_valid, prod_ready;
  result_t res;

  assign in_vec[0] = in_x_i;
  assign in_vec[1] = in_y_i;
  assign in_vec[2] = in_z_i;
  assign in_vec[3] = in_w_i;

  vt4_mat_regs #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mat_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .mat_o      (mat)
  );

  vt4_mul u_mul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .vec_i      (in_vec),
    .mat_i      (mat),
    .valid_o    (prod_valid),
    .ready_i    (prod_ready),
    .prod_o     (prod)
  );

  vt4_sum_sat #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sum_sat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (prod_valid),
    .ready_o     (prod_ready),
    .prod_i      (prod),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign out_x_o     = res.comp[0];
  assign out_y_o     = res.comp[1];
  assign out_z_o     = res.comp[2];
  assign out_w_o     = res.comp[3];
  assign saturated_o = res.sat;

endmodule

// ===== rtl/vt4_checker.sv =====
`include "assert_macros.svh"

module vt4_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] out_x_o,
  input logic [31:0] out_y_o,
  input logic [31:0] out_z_o,
  input logic [31:0] out_w_o,
  input logic        saturated_o
);

  logic [4*32:0] payload;
  logic          any_clamp;

  // whole result beat as one vector
  assign payload = {out_x_o, out_y_o, out_z_o, out_w_o, saturated_o};

  // some component sits at a clamp limit
  assign any_clamp = (out_x_o == 32'h7fffffff) || (out_x_o == 32'h80000000) ||
                     (out_y_o == 32'h7fffffff) || (out_y_o == 32'h80000000) ||
                     (out_z_o == 32'h7fffffff) || (out_z_o == 32'h80000000) ||
                     (out_w_o == 32'h7fffffff) || (out_w_o == 32'h80000000);

  // a stalled result beat stays offered
  `VT4_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result beat dropped")

  // a stalled result beat keeps its payload
  `VT4_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(payload), "payload changed")

  // nothing is offered once reset has been sampled low
  `VT4_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !out_valid_o, "result beat during reset")

  // a draining output lets the whole pipeline move
  `VT4_ASSERT(a_no_bubble_stall, !out_stall_i |-> !in_stall_o, "input stalled with free output")

  // the flag only comes with a clamped component
  `VT4_ASSERT(a_sat_clamped, out_valid_o && saturated_o |-> any_clamp, "saturated without clamp")

endmodule

bind vertex_transform_4x4 vt4_checker u_vt4_checker (.*);
